FILE: design/ttss_pkg.sv
// Shared types and constants for the tick task scheduler table.
`default_nettype none

package ttss_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_DISPATCH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NONE_DUE = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_SWEEP
   } fsm_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  pending;
   } slot_entry_type;

   typedef struct packed {
      logic emit;
      logic keep;
      logic due;
   } slot_flags_type;

endpackage

`default_nettype wire

FILE: design/ttss_if.sv
// Request and response channel interfaces of the tick task scheduler table.
`default_nettype none

interface ttss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  task_tag;
   logic [15:0] first_delay;
   logic [15:0] repeat_period;
   logic [2:0]  slot_number;

   modport source (output valid, output mode, output task_tag, output first_delay,
                   output repeat_period, output slot_number, input ready);
   modport sink   (input valid, input mode, input task_tag, input first_delay,
                   input repeat_period, input slot_number, output ready);
endinterface

interface ttss_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] slot_index;
   logic [7:0] run_tag;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output slot_index, output run_tag, output status,
                   output last, input ready);
   modport sink   (input valid, input slot_index, input run_tag, input status,
                   input last, output ready);
endinterface

`default_nettype wire

FILE: design/ttss_slot_upd.sv
// Per-slot update for tick aging and dispatch of one table entry.
`default_nettype none

module ttss_slot_upd
   import ttss_pkg::*;
(
   input  logic           dispatch,
   input  logic           slot_valid,
   input  slot_entry_type entry_in,
   output slot_entry_type entry_out,
   output slot_flags_type flags
);

   logic pend_nz;
   logic delay_z;
   logic period_nz;

   always_comb begin
      pend_nz   = (entry_in.pending != 8'd0);
      delay_z   = (entry_in.delay == 16'd0);
      period_nz = (entry_in.period != 16'd0);
      entry_out = entry_in;
      flags     = '0;
      if (dispatch) begin
         flags.keep = slot_valid;
         if (slot_valid && pend_nz) begin
            flags.emit        = 1'b1;
            entry_out.pending = entry_in.pending - 8'd1;
            flags.keep        = period_nz;
            flags.due         = period_nz && (entry_in.pending != 8'd1);
         end
      end else begin
         flags.keep = slot_valid;
         if (slot_valid) begin
            if (delay_z) begin
               if (entry_in.pending != 8'hFF) begin
                  entry_out.pending = entry_in.pending + 8'd1;
               end
               if (period_nz) begin
                  entry_out.delay = entry_in.period;
               end
               flags.due = 1'b1;
            end else begin
               entry_out.delay = entry_in.delay - 16'd1;
               flags.due       = pend_nz;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/tick_task_scheduler_table.sv
// Top level of the tick task scheduler table: slot memory, sweep control, response register.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid / ready    | mode, task_tag, first_delay, repeat_period, slot_number
//   rsp     | out | valid / ready    | slot_index, run_tag, status, last
//
// Add, delete and a dispatch with nothing due are answered from the idle state without a sweep.
// Tick and dispatch sweep the slot memory: one read per slot into a read data register,
// then the updated entry is written back to the same memory.
// Reset clears the slot valid and due bits; the memory needs no clearing.
// A dispatch result that finds the response register full holds the sweep until it drains.
// A new request is taken only between sweeps and while the response register can load.
`default_nettype none

module tick_task_scheduler_table
   import ttss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ttss_req_if.sink    req,
   ttss_rsp_if.source  rsp
);

   fsm_type              state_ff, state_in;
   logic                 op_disp_ff, op_disp_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]     p_idx_ff, p_idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [TASK_SLOTS-1:0] due_ff, due_in;

   slot_entry_type       slot_mem_ff [TASK_SLOTS];
   slot_entry_type       rd_data_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           rsp_index_ff, rsp_index_in;
   logic [7:0]           rsp_tag_ff, rsp_tag_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_load;

   logic                 out_free;
   logic                 accept;
   mode_type             req_mode;
   logic                 full;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     del_idx;
   logic                 del_in_range;
   logic                 stall;
   logic                 proc;
   logic                 issue;
   logic                 later_due;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   slot_entry_type       mem_wd;
   logic [IDX_W-1:0]     mem_ra;

   slot_entry_type       upd_entry;
   slot_flags_type       upd_flags;

   ttss_slot_upd u_slot_upd (
      .dispatch   (op_disp_ff),
      .slot_valid (valid_ff[p_idx_ff]),
      .entry_in   (rd_data_ff),
      .entry_out  (upd_entry),
      .flags      (upd_flags)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == FSM_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign req_mode  = mode_type'(req.mode);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.slot_index = rsp_index_ff;
   assign rsp.run_tag    = rsp_tag_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.last       = rsp_last_ff;

   assign full         = &valid_ff;
   assign del_idx      = IDX_W'(req.slot_number);
   assign del_in_range = ($unsigned(req.slot_number) < TASK_SLOTS);

   always_comb begin
      free_idx = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      later_due = 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (IDX_W'(i) > p_idx_ff && due_ff[i]) begin
            later_due = 1'b1;
         end
      end
   end

   assign stall = p_valid_ff && upd_flags.emit && !out_free;
   assign proc  = p_valid_ff && !stall;
   assign issue = (state_ff == FSM_SWEEP) && (rd_cnt_ff != CNT_W'(TASK_SLOTS)) && !stall;
   assign mem_ra = rd_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      op_disp_in    = op_disp_ff;
      rd_cnt_in     = rd_cnt_ff;
      p_valid_in    = p_valid_ff;
      p_idx_in      = p_idx_ff;
      valid_in      = valid_ff;
      due_in        = due_ff;
      mem_we        = 1'b0;
      mem_wa        = p_idx_ff;
      mem_wd        = upd_entry;
      rsp_load      = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_tag_in  = 8'd0;
               rsp_last_in = 1'b1;
               unique case (req_mode)
                  MODE_TICK: begin
                     state_in   = FSM_SWEEP;
                     op_disp_in = 1'b0;
                     rd_cnt_in  = '0;
                     p_valid_in = 1'b0;
                  end
                  MODE_ADD: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_index_in  = 4'(TASK_SLOTS);
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_index_in      = 4'(free_idx);
                        rsp_status_in     = STAT_OK;
                        mem_we            = 1'b1;
                        mem_wa            = free_idx;
                        mem_wd.tag        = req.task_tag;
                        mem_wd.delay      = req.first_delay;
                        mem_wd.period     = req.repeat_period;
                        mem_wd.pending    = 8'd0;
                        valid_in[free_idx] = 1'b1;
                        due_in[free_idx]   = 1'b0;
                     end
                  end
                  MODE_DELETE: begin
                     rsp_load      = 1'b1;
                     rsp_index_in  = 4'(req.slot_number);
                     rsp_status_in = STAT_EMPTY;
                     if (del_in_range) begin
                        if (valid_ff[del_idx]) begin
                           rsp_status_in = STAT_OK;
                        end
                        valid_in[del_idx] = 1'b0;
                        due_in[del_idx]   = 1'b0;
                     end
                  end
                  MODE_DISPATCH: begin
                     if (|due_ff) begin
                        state_in   = FSM_SWEEP;
                        op_disp_in = 1'b1;
                        rd_cnt_in  = '0;
                        p_valid_in = 1'b0;
                     end else begin
                        rsp_load      = 1'b1;
                        rsp_index_in  = 4'(TASK_SLOTS);
                        rsp_status_in = STAT_NONE_DUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_SWEEP: begin
            if (proc) begin
               mem_we              = 1'b1;
               valid_in[p_idx_ff]  = upd_flags.keep;
               due_in[p_idx_ff]    = upd_flags.due;
               if (upd_flags.emit) begin
                  rsp_load      = 1'b1;
                  rsp_index_in  = 4'(p_idx_ff);
                  rsp_tag_in    = rd_data_ff.tag;
                  rsp_status_in = STAT_OK;
                  rsp_last_in   = !later_due;
               end
            end
            if (!stall) begin
               p_valid_in = issue;
               if (issue) begin
                  p_idx_in  = mem_ra;
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               end
            end
            if (rd_cnt_ff == CNT_W'(TASK_SLOTS) && !p_valid_ff) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         p_valid_ff   <= 1'b0;
         rd_cnt_ff    <= '0;
         valid_ff     <= '0;
         due_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_valid_ff   <= p_valid_in;
         rd_cnt_ff    <= rd_cnt_in;
         valid_ff     <= valid_in;
         due_ff       <= due_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_disp_ff <= op_disp_in;
      p_idx_ff   <= p_idx_in;
      if (rsp_load) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= slot_mem_ff[mem_ra];
      end
   end

   a_due_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (due_ff & ~valid_ff) == '0)
      else $error("due bit set on an empty slot");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_W'(TASK_SLOTS))
      else $error("sweep counter past table end");

   a_stall_holds_slot: assert property (@(posedge clock) disable iff (reset)
      stall |=> p_valid_ff && $stable(p_idx_ff))
      else $error("slot in flight lost during stall");

   a_none_due_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STAT_OK) |-> rsp_last_ff)
      else $error("status response without last");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SWEEP) |-> !req.ready)
      else $error("request taken during sweep");

endmodule

`default_nettype wire
